FILE: src/ntc_pkg.sv
package ntc_pkg;

    // Field widths
    localparam int FEAT_W  = 16;
    localparam int LABEL_W = 8;
    localparam int DIST_W  = 33;
    localparam int THR_W   = 16;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int ENT_W   = 5;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MATCH   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

    localparam logic [THR_W-1:0]  THR_RESET = 16'd128;
    localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

    // Query token that walks the row of template cells
    typedef struct packed {
        logic               vld;
        logic [FEAT_W-1:0]  q_rms;
        logic [FEAT_W-1:0]  q_cen;
        logic               found;
        logic [DIST_W-1:0]  best;
        logic [LABEL_W-1:0] lab;
    } scan_t;

endpackage

FILE: src/ntc_cell.sv
module ntc_cell
    import ntc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 4,
    parameter int CNT_W = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [FEAT_W-1:0]  wr_rms,
    input  logic [FEAT_W-1:0]  wr_cen,
    input  logic [LABEL_W-1:0] wr_lab,
    input  logic [CNT_W-1:0]   count,
    input  scan_t              scan_in,
    output scan_t              scan_out
);

    logic [FEAT_W-1:0]  rms_reg;
    logic [FEAT_W-1:0]  cen_reg;
    logic [LABEL_W-1:0] lab_reg;
    scan_t              scan_reg;
    scan_t              scan_next;
    logic [FEAT_W-1:0]  dr;
    logic [FEAT_W-1:0]  dc;
    logic [2*FEAT_W-1:0] sq_r;
    logic [2*FEAT_W-1:0] sq_c;
    logic [DIST_W-1:0]  dist_sq;
    logic               held;
    logic               take;

    // Store the template when this slot is addressed
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == IDX_W'(IDX)))
        begin
            rms_reg <= wr_rms;
            cen_reg <= wr_cen;
            lab_reg <= wr_lab;
        end
    end

    // Squared distance from the passing query to this template
    always_comb
    begin
        dr      = (scan_in.q_rms >= rms_reg) ? (scan_in.q_rms - rms_reg)
                                             : (rms_reg - scan_in.q_rms);
        dc      = (scan_in.q_cen >= cen_reg) ? (scan_in.q_cen - cen_reg)
                                             : (cen_reg - scan_in.q_cen);
        sq_r    = {{FEAT_W{1'b0}}, dr} * {{FEAT_W{1'b0}}, dr};
        sq_c    = {{FEAT_W{1'b0}}, dc} * {{FEAT_W{1'b0}}, dc};
        dist_sq = {1'b0, sq_r} + {1'b0, sq_c};
    end

    // Replace the running best only on a strictly smaller distance
    always_comb
    begin
        held      = (CNT_W'(IDX) < count);
        take      = scan_in.vld && held && (!scan_in.found || (dist_sq < scan_in.best));
        scan_next = scan_in;
        if (take)
        begin
            scan_next.found = 1'b1;
            scan_next.best  = dist_sq;
            scan_next.lab   = lab_reg;
        end
    end

    // Hand the token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign scan_out = scan_reg;

endmodule

FILE: src/nearest_template_classifier.sv
// Nearest-template classifier: holds up to MAX_TEMPLATES labelled templates of two
// unsigned Q8.8 features, one per cell in a row of cells. Each input transaction
// adds a template, clears the table or classifies a query; each gives exactly one
// result transaction. Add, clear and unused op codes load their result into the
// output register as they are accepted. A classify sends the query down the row,
// one cell per cycle, each cell comparing its squared distance against the running
// best (earliest template wins ties), and is reported once the token has left the
// row. A match is reported when the best squared distance is strictly below the
// squared threshold. The threshold may be written only while the block is idle.
module nearest_template_classifier
    import ntc_pkg::*;
#(
    parameter int MAX_TEMPLATES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [THR_W-1:0]     cfg_wr_data,  // match_threshold
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // op[1:0], feat_rms[17:2], feat_centroid[33:18], label[41:34]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata       // status[1:0], match_label[9:2], best_dist_sq[42:10], entries[47:43]
);

    localparam int CNT_W = $clog2(MAX_TEMPLATES + 1);
    localparam int IDX_W = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [THR_W-1:0]    thr_reg;
    logic [2*THR_W-1:0]  thr_sq_reg;

    logic                fin_found_reg;
    logic [DIST_W-1:0]   fin_best_reg;
    logic [LABEL_W-1:0]  fin_lab_reg;

    logic                m_valid_reg;
    logic [STAT_W-1:0]   m_status_reg;
    logic [LABEL_W-1:0]  m_label_reg;
    logic [DIST_W-1:0]   m_best_reg;
    logic [ENT_W-1:0]    m_entries_reg;

    logic [OP_W-1:0]     in_op;
    logic [FEAT_W-1:0]   in_rms;
    logic [FEAT_W-1:0]   in_cen;
    logic [LABEL_W-1:0]  in_lab;
    logic                s_accept;
    logic                out_free;
    logic                full;
    logic                wr_en;
    logic                load_now;
    logic                load_fin;
    logic [STAT_W-1:0]   now_status;
    logic [STAT_W-1:0]   fin_status;
    logic                fin_match;

    scan_t               chain [MAX_TEMPLATES+1];
    logic [MAX_TEMPLATES-1:0] tok_vec;

    // Unpack the input transaction
    assign in_op  = s_tdata[1:0];
    assign in_rms = s_tdata[17:2];
    assign in_cen = s_tdata[33:18];
    assign in_lab = s_tdata[41:34];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign full     = (count_reg >= CNT_W'(MAX_TEMPLATES));
    assign wr_en    = s_accept && (in_op == OP_ADD) && !full;

    // Launch a query token at the head of the row
    always_comb
    begin
        chain[0].vld   = s_accept && (in_op == OP_CLASSIFY);
        chain[0].q_rms = in_rms;
        chain[0].q_cen = in_cen;
        chain[0].found = 1'b0;
        chain[0].best  = DIST_MAX;
        chain[0].lab   = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TEMPLATES; gi++)
        begin : g_cell
            ntc_cell #(
                .IDX   (gi),
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .wr_en    (wr_en),
                .wr_idx   (count_reg[IDX_W-1:0]),
                .wr_rms   (in_rms),
                .wr_cen   (in_cen),
                .wr_lab   (in_lab),
                .count    (count_reg),
                .scan_in  (chain[gi]),
                .scan_out (chain[gi+1])
            );
            assign tok_vec[gi] = chain[gi+1].vld;
        end
    endgenerate

    // Table fill count
    always_comb
    begin
        count_next = count_reg;
        if (s_accept)
        begin
            if (wr_en)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (in_op == OP_CLEAR)
            begin
                count_next = '0;
            end
        end
    end

    // Sequence: idle, token in the row, final report
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (chain[0].vld)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chain[MAX_TEMPLATES].vld)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result status for add, clear and unused operations and for a finished scan
    always_comb
    begin
        now_status = ST_DONE;
        if ((in_op == OP_ADD) && full)
        begin
            now_status = ST_FULL;
        end
        fin_match  = fin_found_reg && (fin_best_reg < {1'b0, thr_sq_reg});
        fin_status = fin_match ? ST_MATCH : ST_NOMATCH;
        load_now   = s_accept && (in_op != OP_CLASSIFY);
        load_fin   = (state_reg == S_FIN) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            thr_reg     <= THR_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            if (load_now || load_fin)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Squared threshold, refreshed every cycle
    always_ff @(posedge clk)
    begin
        thr_sq_reg <= {{THR_W{1'b0}}, thr_reg} * {{THR_W{1'b0}}, thr_reg};
    end

    // Capture the token leaving the row
    always_ff @(posedge clk)
    begin
        if (chain[MAX_TEMPLATES].vld)
        begin
            fin_found_reg <= chain[MAX_TEMPLATES].found;
            fin_best_reg  <= chain[MAX_TEMPLATES].best;
            fin_lab_reg   <= chain[MAX_TEMPLATES].lab;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_now)
        begin
            m_status_reg  <= now_status;
            m_label_reg   <= '0;
            m_best_reg    <= '0;
            m_entries_reg <= ENT_W'(count_next);
        end
        else if (load_fin)
        begin
            m_status_reg  <= fin_status;
            m_label_reg   <= fin_match ? fin_lab_reg : '0;
            m_best_reg    <= fin_best_reg;
            m_entries_reg <= ENT_W'(count_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_entries_reg, m_best_reg, m_label_reg, m_status_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TEMPLATES))
        else $error("template count above table size");

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one query token in the row");

    a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (tok_vec == '0))
        else $error("query token in the row while idle");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[MAX_TEMPLATES].vld |-> (state_reg == S_SCAN))
        else $error("token left the row outside a scan");

    a_full_add_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && (in_op == OP_ADD) && full) |=> $stable(count_reg))
        else $error("refused add changed the count");
`endif

endmodule

FILE: sim/nearest_template_classifier_tb.sv
`timescale 1ns / 1ps

module nearest_template_classifier_tb;
    import ntc_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FEAT_W-1:0]  rms;
        logic [FEAT_W-1:0]  cen;
        logic [LABEL_W-1:0] label;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [LABEL_W-1:0] match_label;
        logic [DIST_W-1:0]  dist_sq;
        logic [ENT_W-1:0]   entries;
    } result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [THR_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Commands waiting to go out, and results owed by the block
    cmd_t    cmd_fifo[$];
    result_t result_fifo[$];
    cmd_t    drive_cmd = '0;
    int      send_gap = 0;
    int      recv_gap = 0;
    bit      send_idle_en = 1'b1;
    bit      recv_idle_en = 1'b1;

    // Shadow of the template table, updated on each accepted command
    logic [FEAT_W-1:0]  tmpl_rms[TABLE_DEPTH];
    logic [FEAT_W-1:0]  tmpl_cen[TABLE_DEPTH];
    logic [LABEL_W-1:0] tmpl_label[TABLE_DEPTH];
    int                 tmpl_count = 0;
    logic [THR_W-1:0]   match_thr = THR_RESET;

    // Table as seen while generating stimulus, used to aim queries
    logic [FEAT_W-1:0]  plan_rms[TABLE_DEPTH];
    logic [FEAT_W-1:0]  plan_cen[TABLE_DEPTH];
    int                 plan_count = 0;

    int err_count = 0;
    int cycle_count = 0;
    int n_done = 0;
    int n_full = 0;
    int n_match = 0;
    int n_nomatch = 0;
    int n_thr_writes = 0;

    nearest_template_classifier #(
        .MAX_TEMPLATES(TABLE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_fifo.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got_v,
                 want_v);
        err_count++;
    endtask

    // Update the table shadow and queue the result one command should give
    task automatic apply_command(input cmd_t c);
        result_t           r;
        logic [FEAT_W-1:0] dr;
        logic [FEAT_W-1:0] dc;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] thr_sq;
        logic              hit;
        r = '0;
        r.status = ST_DONE;
        case (c.op)
            OP_ADD:
            begin
                if (tmpl_count < TABLE_DEPTH)
                begin
                    tmpl_rms[tmpl_count] = c.rms;
                    tmpl_cen[tmpl_count] = c.cen;
                    tmpl_label[tmpl_count] = c.label;
                    tmpl_count++;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            OP_CLEAR:
            begin
                tmpl_count = 0;
            end
            OP_CLASSIFY:
            begin
                hit = 1'b0;
                r.dist_sq = DIST_MAX;
                for (int i = 0; i < tmpl_count; i++)
                begin
                    dr = (tmpl_rms[i] >= c.rms) ? tmpl_rms[i] - c.rms : c.rms - tmpl_rms[i];
                    dc = (tmpl_cen[i] >= c.cen) ? tmpl_cen[i] - c.cen : c.cen - tmpl_cen[i];
                    d = DIST_W'(dr) * DIST_W'(dr) + DIST_W'(dc) * DIST_W'(dc);
                    // strict compare keeps the earliest template on a tie
                    if (!hit || d < r.dist_sq)
                    begin
                        hit = 1'b1;
                        r.dist_sq = d;
                        r.match_label = tmpl_label[i];
                    end
                end
                thr_sq = DIST_W'(match_thr) * DIST_W'(match_thr);
                if (hit && r.dist_sq < thr_sq)
                begin
                    r.status = ST_MATCH;
                end
                else
                begin
                    r.status = ST_NOMATCH;
                    r.match_label = '0;
                end
            end
            default:
            begin
            end
        endcase
        r.entries = ENT_W'(tmpl_count);
        result_fifo = {result_fifo, r};
    endtask

    // Drive commands, drawing an idle gap after each transaction when idle gaps are enabled
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t nxt;
        int   gap;
        logic fire;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            fire = s_tvalid && s_tready;
            if (fire)
            begin
                apply_command(drive_cmd);
                gap = send_idle_en ? $urandom_range(0, 4) : 0;
            end
            else
            begin
                gap = send_gap;
            end
            if (s_tvalid && !fire)
            begin
                // hold until accepted
            end
            else if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= gap - 1;
            end
            else if (cmd_fifo.size() > 0)
            begin
                nxt = cmd_fifo.pop_front();
                drive_cmd <= nxt;
                s_tdata <= S_TDATA_W'({nxt.label, nxt.cen, nxt.rms, nxt.op});
                s_tvalid <= 1'b1;
                send_gap <= 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Check results against the oldest pending one, stalling at random when enabled
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        int      gap;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tdata[1:0];
                got.match_label = m_tdata[9:2];
                got.dist_sq = m_tdata[42:10];
                got.entries = m_tdata[47:43];
                if (result_fifo.size() == 0)
                begin
                    report_mismatch("result with none pending", 64'(m_tdata), 64'd0);
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.match_label != want.match_label)
                        report_mismatch("match_label", 64'(got.match_label),
                                        64'(want.match_label));
                    if (got.dist_sq != want.dist_sq)
                        report_mismatch("best_dist_sq", 64'(got.dist_sq), 64'(want.dist_sq));
                    if (got.entries != want.entries)
                        report_mismatch("entries", 64'(got.entries), 64'(want.entries));
                    case (want.status)
                        ST_FULL:  n_full++;
                        ST_MATCH: n_match++;
                        ST_NOMATCH: n_nomatch++;
                        default:  n_done++;
                    endcase
                end
                gap = recv_idle_en ? $urandom_range(0, 4) : 0;
            end
            else
            begin
                gap = recv_gap;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap <= 0;
            end
        end
    end

    // Queue one command and track what the table will hold
    task automatic push_cmd(input logic [OP_W-1:0] op, input logic [FEAT_W-1:0] rms,
                            input logic [FEAT_W-1:0] cen, input logic [LABEL_W-1:0] lab);
        cmd_t c;
        c.op = op;
        c.rms = rms;
        c.cen = cen;
        c.label = lab;
        if (op == OP_ADD && plan_count < TABLE_DEPTH)
        begin
            plan_rms[plan_count] = rms;
            plan_cen[plan_count] = cen;
            plan_count++;
        end
        else if (op == OP_CLEAR)
        begin
            plan_count = 0;
        end
        cmd_fifo = {cmd_fifo, c};
    endtask

    // Offset a feature by up to span either way, clamped to the Q8.8 range
    function automatic logic [FEAT_W-1:0] nudge(input int base, input int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return FEAT_W'(v);
    endfunction

    // Draw a random feature up to hi, and a random label
    function automatic logic [FEAT_W-1:0] rand_feat(input int hi);
        return FEAT_W'($urandom_range(0, hi));
    endfunction

    function automatic logic [LABEL_W-1:0] rand_lab();
        return LABEL_W'($urandom_range(0, 255));
    endfunction

    // Stall until every queued command has been answered
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmd_fifo.size() != 0 || s_tvalid || result_fifo.size() != 0);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        match_thr = value;
        n_thr_writes++;
    endtask

    // Mostly adds and aimed queries, with some clears, unused ops and noise
    task automatic run_phase(input logic [THR_W-1:0] thr, input int n_items,
                             input int feat_hi, input bit idle_en);
        int roll;
        int k;
        int span;
        write_threshold(thr);
        send_idle_en = idle_en;
        recv_idle_en = idle_en;
        span = (int'(thr) >> 1) + 4;
        if (span > 4000)
            span = 4000;
        for (int n = 0; n < n_items; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                if (plan_count > 0 && $urandom_range(0, 9) == 0)
                begin
                    // same features as an existing template to force a tie
                    k = $urandom_range(0, plan_count - 1);
                    push_cmd(OP_ADD, plan_rms[k], plan_cen[k], rand_lab());
                end
                else
                begin
                    push_cmd(OP_ADD, rand_feat(feat_hi), rand_feat(feat_hi), rand_lab());
                end
            end
            else if (roll < 92)
            begin
                if (plan_count > 0 && $urandom_range(0, 3) != 0)
                begin
                    k = $urandom_range(0, plan_count - 1);
                    if ($urandom_range(0, 4) == 0)
                        push_cmd(OP_CLASSIFY, plan_rms[k], plan_cen[k], rand_lab());
                    else
                        push_cmd(OP_CLASSIFY, nudge(int'(plan_rms[k]), span),
                                 nudge(int'(plan_cen[k]), span), rand_lab());
                end
                else
                begin
                    push_cmd(OP_CLASSIFY, rand_feat(feat_hi), rand_feat(feat_hi),
                             rand_lab());
                end
            end
            else if (roll < 95)
            begin
                push_cmd(OP_CLEAR, rand_feat(65535), rand_feat(65535), rand_lab());
            end
            else
            begin
                push_cmd(OP_W'($urandom_range(0, 3)), rand_feat(65535), rand_feat(65535),
                         rand_lab());
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pass at the reset threshold
        push_cmd(OP_CLASSIFY, 16'h0000, 16'h0000, 8'h00);
        push_cmd(OP_ADD, 16'h0000, 16'h0000, 8'h00);
        push_cmd(OP_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_cmd(OP_CLASSIFY, 16'h0000, 16'h0000, 8'h3C);
        push_cmd(OP_CLASSIFY, 16'hFFFF, 16'hFFFF, 8'h00);
        push_cmd(OP_CLASSIFY, 16'hFFFF, 16'h0000, 8'h00);
        push_cmd(OP_ADD, 16'h0000, 16'h0000, 8'hA5);
        push_cmd(OP_CLASSIFY, 16'h0000, 16'h0040, 8'h00);
        push_cmd(OP_CLASSIFY, 16'h0000, 16'h0080, 8'h00);
        push_cmd(OP_CLASSIFY, 16'h007F, 16'h0000, 8'h00);
        // fill the table, then push past it
        while (plan_count < TABLE_DEPTH)
            push_cmd(OP_ADD, rand_feat(65535), rand_feat(65535), rand_lab());
        push_cmd(OP_ADD, 16'h1234, 16'h4321, 8'h77);
        push_cmd(OP_CLASSIFY, rand_feat(65535), rand_feat(65535), 8'hFF);
        push_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_cmd(OP_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_cmd(OP_CLASSIFY, 16'h0000, 16'h0000, 8'h00);
        push_cmd(OP_UNUSED, 16'h0000, 16'h0000, 8'h00);
        wait_drained();

        // Random passes over a spread of thresholds
        run_phase(16'hFFFF, 110, 65535, 1'b1);
        run_phase(16'h0000, 100, 65535, 1'b0);
        run_phase(THR_W'($urandom_range(1, 65534)), 110, 65535, 1'b1);
        run_phase(THR_W'(128), 120, 1023, 1'b1);
        run_phase(16'h0001, 110, 511, 1'b1);

        repeat (2 * (TABLE_DEPTH + 2)) @(posedge clk);

        $display("Ran %0d results over %0d threshold settings", n_done + n_full + n_match
                 + n_nomatch, n_thr_writes + 1);
        $display("  %0d matched, %0d rejected, %0d refused adds, %0d other", n_match,
                 n_nomatch, n_full, n_done);
        if (err_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", err_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
